// File: rtl/core/pstl_pkg.sv
`timescale 1ns / 1ps

package pstl_pkg;

  // configuration register indexes
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_TARGET_REFERENCE = 2'd0;
  localparam reg_index_t REG_SETTLE_TICKS     = 2'd1;
  localparam reg_index_t REG_STEP_LIMIT       = 2'd2;

  localparam logic [15:0] SETTLE_RESET = 16'd400;
  localparam logic [15:0] LIMIT_RESET  = 16'd1000;

  localparam logic [4:0] START_OFFSET = 5'd29;
  localparam logic [4:0] NEAR_BAND    = 5'd20;
  localparam logic [4:0] DUTY_GAIN    = 5'd17;
  localparam logic [3:0] MAX_LEVEL    = 4'd12;

  typedef struct packed {
    logic [11:0] target_reference;
    logic [15:0] settle_ticks;
    logic [15:0] step_limit;
  } trim_cfg_t;

  typedef struct packed {
    logic [15:0]        hold_count;
    logic [15:0]        step_count;
    logic [3:0]         last_level;
    logic signed [15:0] setpoint;
    logic signed [15:0] estimate;
    logic signed [15:0] display_speed;
    logic [15:0]        duty_hold;
  } trim_state_t;

  typedef struct packed {
    logic [15:0]        drive_duty;
    logic signed [15:0] shown_speed;
    logic               holding;
    logic               limit_reached;
  } trim_result_t;

  // x / 3 for x below 2**16, reciprocal multiply
  function automatic logic [15:0] div3_wide(input logic [15:0] x);
    logic [32:0] prod;
    prod = {17'd0, x} * 33'd43691;
    return prod[32:17];
  endfunction

  // x / 3 for x up to the near band
  function automatic logic [2:0] div3_near(input logic [4:0] x);
    logic [8:0] prod;
    prod = {4'd0, x} * 9'd11;
    return prod[7:5];
  endfunction

  function automatic logic [4:0] level_offset(input logic [3:0] lvl);
    logic [4:0] off;
    case (lvl)
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd26;
      4'd3:    off = 5'd23;
      4'd4:    off = 5'd21;
      4'd5:    off = 5'd18;
      4'd6:    off = 5'd16;
      4'd7:    off = 5'd13;
      4'd8:    off = 5'd11;
      4'd9:    off = 5'd8;
      4'd10:   off = 5'd6;
      4'd11:   off = 5'd3;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  function automatic logic [15:0] level_duty(input logic [3:0] lvl);
    logic [15:0] duty;
    case (lvl)
      4'd0:    duty = 16'd500;
      4'd1:    duty = 16'd452;
      4'd2:    duty = 16'd403;
      4'd3:    duty = 16'd370;
      4'd4:    duty = 16'd336;
      4'd5:    duty = 16'd297;
      4'd6:    duty = 16'd264;
      4'd7:    duty = 16'd215;
      4'd8:    duty = 16'd164;
      4'd9:    duty = 16'd110;
      4'd10:   duty = 16'd64;
      4'd11:   duty = 16'd25;
      default: duty = 16'd0;
    endcase
    return duty;
  endfunction

endpackage

// File: rtl/core/pump_speed_trim_loop.sv
`timescale 1ns / 1ps

// speed trim loop for a pump drive. every request carries one control tick:
// a measured speed sample and a speed level (0 to 12). the block answers each
// request with exactly one result: the drive duty, the speed to display, a
// holding flag (settle hold still running after this tick) and a flag that
// says the tabled per-level duty was used because the step limit was hit.
// a level change restarts the settle hold and clears the step count; level 0
// keeps the previous setpoint. throughput is one request per clock while the
// result register has room; out_ready back-pressure stalls it. a request lands
// in an input register, the whole tick update runs in one combinational pass
// into the result register and the loop state. the critical path is the tick
// datapath (up step, down step with a reciprocal divide by three, duty scale).
// configuration writes (target reference, settle ticks, step limit) take
// effect at once and are expected only while no request is in flight.

module pump_speed_trim_loop (
  input  logic                        clk,
  input  logic                        rst,

  // configuration write port
  input  logic                        cfg_write,
  input  pstl_pkg::reg_index_t        cfg_index,
  input  logic [15:0]                 cfg_data,

  // tick requests
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [11:0]                 measured_speed,
  input  logic [3:0]                  speed_level,

  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 drive_duty,
  output logic signed [15:0]          shown_speed,
  output logic                        holding,
  output logic                        limit_reached
);

  pstl_pkg::trim_cfg_t    cfg;
  pstl_pkg::trim_state_t  st, st_next;
  pstl_pkg::trim_result_t res;

  logic        in_full;
  logic [11:0] meas_q;
  logic [3:0]  level_q;
  logic        out_space;
  logic        advance;

  // a held request moves on when the result register has room
  assign advance  = in_full && out_space;
  assign in_ready = !in_full || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_reference <= 12'd0;
      cfg.settle_ticks     <= pstl_pkg::SETTLE_RESET;
      cfg.step_limit       <= pstl_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pstl_pkg::REG_TARGET_REFERENCE: cfg.target_reference <= cfg_data[11:0];
        pstl_pkg::REG_SETTLE_TICKS:     cfg.settle_ticks     <= cfg_data;
        pstl_pkg::REG_STEP_LIMIT:       cfg.step_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_q  <= measured_speed;
      level_q <= speed_level;
    end
  end

  // loop state, updated once per request as it leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // one tick of the trim loop
  pstl_calc u_calc (
    .cfg     (cfg),
    .st      (st),
    .meas    (meas_q),
    .level   (level_q),
    .st_next (st_next),
    .res     (res)
  );

  // result register
  pstl_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .res           (res),
    .space         (out_space),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_duty    (drive_duty),
    .shown_speed   (shown_speed),
    .holding       (holding),
    .limit_reached (limit_reached)
  );

endmodule

// File: rtl/core/pstl_calc.sv
`timescale 1ns / 1ps

module pstl_calc (
  input  pstl_pkg::trim_cfg_t    cfg,
  input  pstl_pkg::trim_state_t  st,
  input  logic [11:0]            meas,
  input  logic [3:0]             level,
  output pstl_pkg::trim_state_t  st_next,
  output pstl_pkg::trim_result_t res
);

  logic signed [17:0] off_w, near_w;
  logic signed [17:0] ref_w, meas_w, disp_w, sp_w, init_w;
  logic signed [17:0] sp_x, est0_x, est1_x, est2_x;
  logic signed [17:0] up_dist, dn_dist, est1_w, est2_w, gap_w;
  logic signed [15:0] disp0, sp, est0, est1, est2;
  logic [15:0]        hold_dec, hold_new, step_new, sc1, sc2, third, duty_calc, tab_duty;
  logic [22:0]        duty_prod;
  logic               level_change, adjust, level_valid, up_step, dn_step, limited;

  always_comb begin
    off_w  = $signed({13'd0, pstl_pkg::START_OFFSET});
    near_w = $signed({13'd0, pstl_pkg::NEAR_BAND});
    ref_w  = $signed({6'd0, cfg.target_reference});
    meas_w = $signed({6'd0, meas});

    // hold countdown and display seed
    hold_dec = (st.hold_count != 16'd0) ? st.hold_count - 16'd1 : 16'd0;
    disp_w   = meas_w - off_w;
    disp0    = (st.display_speed == 16'sd0) ? disp_w[15:0] : st.display_speed;

    level_change = (level != st.last_level);
    hold_new     = level_change ? cfg.settle_ticks : hold_dec;
    step_new     = level_change ? 16'd0 : st.step_count;
    adjust       = (hold_new == 16'd0);

    // setpoint and estimate seed
    level_valid = (level != 4'd0) && (level <= pstl_pkg::MAX_LEVEL);
    sp_w        = ref_w - $signed({13'd0, pstl_pkg::level_offset(level)});
    sp          = level_valid ? sp_w[15:0] : st.setpoint;
    init_w      = ref_w - off_w;
    est0        = (st.estimate == 16'sd0) ? init_w[15:0] : st.estimate;
    sp_x        = {{2{sp[15]}}, sp};
    est0_x      = {{2{est0[15]}}, est0};

    // upward step
    up_step = (step_new < cfg.step_limit) && (est0 < sp);
    up_dist = sp_x - est0_x;
    if (up_dist > near_w) begin
      est1_w = est0_x + (up_dist >>> 1);
    end else if (meas_w > sp_x) begin
      est1_w = est0_x + $signed({15'd0, pstl_pkg::div3_near(up_dist[4:0])});
    end else begin
      est1_w = est0_x + ((sp_x - meas_w) >>> 1);
    end
    est1   = up_step ? est1_w[15:0] : est0;
    sc1    = step_new + {15'd0, up_step};
    est1_x = {{2{est1[15]}}, est1};

    // downward step, sees the updated estimate
    dn_step = (sc1 < cfg.step_limit) && (est1 > sp);
    dn_dist = est1_x - sp_x;
    third   = pstl_pkg::div3_wide(dn_dist[15:0]);
    if (dn_dist > near_w) begin
      est2_w = est1_x - $signed({1'b0, third, 1'b0});
    end else if (meas_w < sp_x) begin
      est2_w = est1_x - $signed({15'd0, pstl_pkg::div3_near(dn_dist[4:0])});
    end else begin
      est2_w = est1_x - ((meas_w - sp_x) >>> 1);
    end
    est2   = dn_step ? est2_w[15:0] : est1;
    sc2    = sc1 + {15'd0, dn_step};
    est2_x = {{2{est2[15]}}, est2};

    // duty from the gap to the reference, floored and saturated
    gap_w     = ref_w - est2_x;
    duty_prod = {6'd0, gap_w[16:0]} * {18'd0, pstl_pkg::DUTY_GAIN};
    if (gap_w < 18'sd0) begin
      duty_calc = 16'd0;
    end else if (duty_prod > 23'd65535) begin
      duty_calc = 16'hFFFF;
    end else begin
      duty_calc = duty_prod[15:0];
    end

    limited  = (sc2 == cfg.step_limit);
    tab_duty = pstl_pkg::level_duty((level > pstl_pkg::MAX_LEVEL) ? pstl_pkg::MAX_LEVEL : level);

    st_next            = st;
    st_next.hold_count = hold_new;
    st_next.last_level = level;
    if (adjust) begin
      st_next.setpoint      = sp;
      st_next.estimate      = est2;
      st_next.step_count    = sc2;
      st_next.display_speed = limited ? sp : est2;
      st_next.duty_hold     = limited ? tab_duty : duty_calc;
    end else begin
      st_next.step_count    = step_new;
      st_next.display_speed = disp0;
    end

    res.drive_duty    = st_next.duty_hold;
    res.shown_speed   = st_next.display_speed;
    res.holding       = (hold_new != 16'd0);
    res.limit_reached = adjust && limited;
  end

endmodule

// File: rtl/core/pstl_out.sv
`timescale 1ns / 1ps

module pstl_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  pstl_pkg::trim_result_t res,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            drive_duty,
  output logic signed [15:0]     shown_speed,
  output logic                   holding,
  output logic                   limit_reached
);

  pstl_pkg::trim_result_t res_q;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign drive_duty    = res_q.drive_duty;
  assign shown_speed   = res_q.shown_speed;
  assign holding       = res_q.holding;
  assign limit_reached = res_q.limit_reached;

endmodule
